/* rtl/core/bsel_pkg.sv */
// Shared constants, codes and control types of the bounded sorted event list.
package bsel_pkg;

	localparam int DEPTH    = 16;
	localparam int TAG_BITS = 16;
	localparam int TIME_W   = 32;
	localparam int MODE_W   = 3;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PURGE  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SHRINK = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PURGE,
		ST_STATUS,
		ST_READ
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;        // capture the accepted item
		logic exec;        // apply insert, shrink or clear
		logic purge_step;  // drop the head entry
		logic rd_clear;    // rewind the read pointer
		logic rd_advance;  // move to the next entry
		logic show_entry;  // result carries a stored entry
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              empty;
		logic              purge_hit;
		logic              rd_last;
	} sts_t;

endpackage

/* rtl/core/bsel_ctrl.sv */
// Controller state machine of the bounded sorted event list.
module bsel_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  bsel_pkg::sts_t  sts,
	output bsel_pkg::cmd_t  cmd
);

	bsel_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsel_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt      = state_q;
		cmd            = '0;
		in_stall       = 1'b1;
		out_valid      = 1'b0;
		case (state_q)
			bsel_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = bsel_pkg::ST_EXEC;
				end
			end
			bsel_pkg::ST_EXEC: begin
				cmd.exec     = 1'b1;
				cmd.rd_clear = 1'b1;
				case (sts.mode)
					bsel_pkg::MODE_PURGE: state_nxt = bsel_pkg::ST_PURGE;
					bsel_pkg::MODE_READ: begin
						state_nxt = sts.empty ? bsel_pkg::ST_STATUS : bsel_pkg::ST_READ;
					end
					default: state_nxt = bsel_pkg::ST_STATUS;
				endcase
			end
			bsel_pkg::ST_PURGE: begin
				// drop one head entry a cycle while it lies below the bound
				if (sts.purge_hit) begin
					cmd.purge_step = 1'b1;
				end else begin
					state_nxt = bsel_pkg::ST_STATUS;
				end
			end
			bsel_pkg::ST_STATUS: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_nxt = bsel_pkg::ST_IDLE;
				end
			end
			bsel_pkg::ST_READ: begin
				out_valid      = 1'b1;
				cmd.show_entry = 1'b1;
				if (!out_stall) begin
					cmd.rd_advance = 1'b1;
					if (sts.rd_last) begin
						state_nxt = bsel_pkg::ST_IDLE;
					end
				end
			end
			default: state_nxt = bsel_pkg::ST_IDLE;
		endcase
	end

endmodule

/* rtl/core/bsel_dp.sv */
// Datapath of the bounded sorted event list: entry stores, count, limit, read pointer.
module bsel_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [bsel_pkg::CNT_W-1:0]    keep_limit,
	input  logic [bsel_pkg::MODE_W-1:0]   mode,
	input  logic [bsel_pkg::TIME_W-1:0]   time_value,
	input  logic [bsel_pkg::TAG_BITS-1:0] entry_tag,
	input  logic [bsel_pkg::CNT_W-1:0]    keep_count,
	input  bsel_pkg::cmd_t                cmd,
	output bsel_pkg::sts_t                sts,
	output logic [bsel_pkg::CNT_W-1:0]    count,
	output logic                          entry_valid,
	output logic [bsel_pkg::TIME_W-1:0]   entry_time,
	output logic [bsel_pkg::TAG_BITS-1:0] out_tag,
	output logic                          last
);

	logic [bsel_pkg::TIME_W-1:0]   key_q [bsel_pkg::DEPTH];
	logic [bsel_pkg::TAG_BITS-1:0] tag_q [bsel_pkg::DEPTH];
	logic [bsel_pkg::CNT_W-1:0]    held_q;
	logic [bsel_pkg::CNT_W-1:0]    limit_q;
	logic [bsel_pkg::MODE_W-1:0]   mode_q;
	logic [bsel_pkg::TIME_W-1:0]   time_q;
	logic [bsel_pkg::TAG_BITS-1:0] tag_in_q;
	logic [bsel_pkg::CNT_W-1:0]    kc_q;
	logic [bsel_pkg::IDX_W-1:0]    rd_idx_q;

	logic [bsel_pkg::DEPTH-1:0]    gt;
	logic [bsel_pkg::CNT_W-1:0]    lim;
	logic [bsel_pkg::CNT_W:0]      held_inc;
	logic                          do_ins;

	assign lim      = (limit_q > bsel_pkg::CNT_W'(bsel_pkg::DEPTH)) ?
	                  bsel_pkg::CNT_W'(bsel_pkg::DEPTH) : limit_q;
	assign held_inc = {1'b0, held_q} + 1'b1;
	assign do_ins   = cmd.exec && (mode_q == bsel_pkg::MODE_INSERT);

	// An entry moves on insert when it is empty or later than the new time
	always_comb begin
		for (int i = 0; i < bsel_pkg::DEPTH; i++) begin
			gt[i] = (bsel_pkg::CNT_W'(i) >= held_q) || (key_q[i] > time_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			time_q   <= time_value;
			tag_in_q <= entry_tag;
			kc_q     <= keep_count;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < bsel_pkg::DEPTH; i++) begin
			if (do_ins && gt[i]) begin
				if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
					key_q[i] <= key_q[(i > 0) ? i - 1 : 0];
					tag_q[i] <= tag_q[(i > 0) ? i - 1 : 0];
				end else begin
					key_q[i] <= time_q;
					tag_q[i] <= tag_in_q;
				end
			end else if (cmd.purge_step && i < bsel_pkg::DEPTH - 1) begin
				key_q[i] <= key_q[(i < bsel_pkg::DEPTH - 1) ? i + 1 : i];
				tag_q[i] <= tag_q[(i < bsel_pkg::DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			limit_q <= bsel_pkg::CNT_W'(bsel_pkg::DEPTH);
		end else begin
			if (cfg_valid) begin
				limit_q <= keep_limit;
			end
			if (cmd.purge_step) begin
				held_q <= held_q - 1'b1;
			end else if (cmd.exec) begin
				case (mode_q)
					bsel_pkg::MODE_INSERT: begin
						// grow by one unless full or already at or past the limit
						if (held_q < bsel_pkg::CNT_W'(bsel_pkg::DEPTH) &&
						    held_inc <= {1'b0, lim}) begin
							held_q <= held_inc[bsel_pkg::CNT_W-1:0];
						end
					end
					bsel_pkg::MODE_SHRINK: begin
						if (held_q > kc_q) begin
							held_q <= kc_q;
						end
					end
					bsel_pkg::MODE_CLEAR: held_q <= '0;
					default: held_q <= held_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.rd_clear) begin
			rd_idx_q <= '0;
		end else if (cmd.rd_advance) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
	end

	assign sts.mode      = mode_q;
	assign sts.empty     = (held_q == '0);
	assign sts.purge_hit = (held_q != '0) && (key_q[0] < time_q);
	assign sts.rd_last   = ({1'b0, rd_idx_q} + 1'b1) == {{(bsel_pkg::IDX_W + 1 -
	                       bsel_pkg::CNT_W){1'b0}}, held_q};

	assign count       = held_q;
	assign entry_valid = cmd.show_entry;
	assign entry_time  = cmd.show_entry ? key_q[rd_idx_q] : '0;
	assign out_tag     = cmd.show_entry ? tag_q[rd_idx_q] : '0;
	assign last        = !cmd.show_entry || sts.rd_last;

endmodule

/* rtl/core/bounded_sorted_event_list_top.sv */
// Top level of the bounded sorted event list: controller plus datapath.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  input     | in_valid / in_stall    | mode, time_value, entry_tag, keep_count
//  result    | out_valid / out_stall  | count, entry_valid, entry_time, out_tag, last
//  config    | cfg_valid / cfg_ready  | keep_limit
//
// One item is worked at a time; in_stall is high from acceptance until its last
// result is taken. Insert, shrink, clear, undefined modes and a read of an empty
// list go through execute to status. Purge adds the purge loop before status,
// one head entry shifted out per cycle while below the bound; read goes to
// read-out, one held entry per cycle via the read pointer mux while out_stall is low.
// Reset empties the list and sets the keep limit to DEPTH; the entry stores
// are not cleared. A stalled result holds its payload until taken.
module bounded_sorted_event_list_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bsel_pkg::CNT_W-1:0]    keep_limit,
	// input items
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bsel_pkg::MODE_W-1:0]   mode,
	input  logic [bsel_pkg::TIME_W-1:0]   time_value,
	input  logic [bsel_pkg::TAG_BITS-1:0] entry_tag,
	input  logic [bsel_pkg::CNT_W-1:0]    keep_count,
	// result items
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bsel_pkg::CNT_W-1:0]    count,
	output logic                          entry_valid,
	output logic [bsel_pkg::TIME_W-1:0]   entry_time,
	output logic [bsel_pkg::TAG_BITS-1:0] out_tag,
	output logic                          last
);

	bsel_pkg::cmd_t cmd;
	bsel_pkg::sts_t sts;

	// Limit register takes a write every cycle it is offered
	assign cfg_ready = 1'b1;

	// Sequence: accept, execute, optional purge loop, then status or read-out
	bsel_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Sorted stores, count, limit and the read pointer
	bsel_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.keep_limit  (keep_limit),
		.mode        (mode),
		.time_value  (time_value),
		.entry_tag   (entry_tag),
		.keep_count  (keep_count),
		.cmd         (cmd),
		.sts         (sts),
		.count       (count),
		.entry_valid (entry_valid),
		.entry_time  (entry_time),
		.out_tag     (out_tag),
		.last        (last)
	);

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the bounded sorted event list: driver, monitor and list predictor.
`timescale 1ns / 100ps

module testbench;

	// Mode codes the block treats as no-ops (status only)
	localparam logic [bsel_pkg::MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
	localparam logic [bsel_pkg::MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

	localparam int CALM_CYCLES = 4;       // quiet cycles before a keep limit write
	localparam int DRAIN_CYCLES = 24;     // settle time after the last result
	localparam int CYCLE_LIMIT = 400000;  // watchdog
	localparam int BLOCK_ITEMS = 33;      // random items between keep limit writes

	typedef enum logic [1:0] {
		OP_ITEM,   // one input item
		OP_LIMIT,  // keep limit write, only while the list is quiet
		OP_PACE    // change sender and receiver idle rates
	} op_kind_t;

	typedef struct {
		op_kind_t                        kind;
		logic [bsel_pkg::MODE_W-1:0]     mode;
		logic [bsel_pkg::TIME_W-1:0]     stamp;
		logic [bsel_pkg::TAG_BITS-1:0]   tag;
		logic [bsel_pkg::CNT_W-1:0]      keep;
		logic [bsel_pkg::CNT_W-1:0]      new_limit;
		int unsigned                     send_pct;
		int unsigned                     recv_pct;
	} list_op_t;

	typedef struct packed {
		logic [bsel_pkg::CNT_W-1:0]    count;
		logic                          entry_valid;
		logic [bsel_pkg::TIME_W-1:0]   entry_time;
		logic [bsel_pkg::TAG_BITS-1:0] out_tag;
		logic                          last;
	} list_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [bsel_pkg::CNT_W-1:0]    keep_limit;
	logic                          in_valid;
	logic                          in_stall;
	logic [bsel_pkg::MODE_W-1:0]   mode;
	logic [bsel_pkg::TIME_W-1:0]   time_value;
	logic [bsel_pkg::TAG_BITS-1:0] entry_tag;
	logic [bsel_pkg::CNT_W-1:0]    keep_count;
	logic                          out_valid;
	logic                          out_stall;
	logic [bsel_pkg::CNT_W-1:0]    count;
	logic                          entry_valid;
	logic [bsel_pkg::TIME_W-1:0]   entry_time;
	logic [bsel_pkg::TAG_BITS-1:0] out_tag;
	logic                          last;

	list_op_t     pending_ops[$];
	list_result_t due_results[$];

	// Predicted list contents, limit and fill level
	logic [bsel_pkg::TIME_W-1:0]   shadow_time[bsel_pkg::DEPTH];
	logic [bsel_pkg::TAG_BITS-1:0] shadow_tag[bsel_pkg::DEPTH];
	int unsigned                   shadow_held = 0;
	logic [bsel_pkg::CNT_W-1:0]    limit_now = bsel_pkg::CNT_W'(bsel_pkg::DEPTH);

	int unsigned send_idle = 9;
	int unsigned recv_idle = 79;
	logic        in_acc = 1'b0;
	logic        cfg_acc = 1'b0;
	int unsigned calm = 0;
	int unsigned cycles = 0;
	int unsigned errors = 0;
	int          limit_plan[9] = '{16, 5, 0, 12, 31, 1, 20, 9, 16};

	bounded_sorted_event_list_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.keep_limit (keep_limit),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.time_value (time_value),
		.entry_tag  (entry_tag),
		.keep_count (keep_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.count      (count),
		.entry_valid(entry_valid),
		.entry_time (entry_time),
		.out_tag    (out_tag),
		.last       (last)
	);

	always #2 clk = ~clk;

	function automatic list_op_t make_item(input logic [bsel_pkg::MODE_W-1:0] m,
			input logic [bsel_pkg::TIME_W-1:0] t, input logic [bsel_pkg::TAG_BITS-1:0] tg,
			input logic [bsel_pkg::CNT_W-1:0] kc);
		list_op_t op;
		op = '{kind: OP_ITEM, mode: m, stamp: t, tag: tg, keep: kc,
			new_limit: '0, send_pct: 0, recv_pct: 0};
		return op;
	endfunction

	function automatic list_op_t make_limit(input int lim);
		list_op_t op;
		op = make_item(bsel_pkg::MODE_READ, '0, '0, '0);
		op.kind = OP_LIMIT;
		op.new_limit = bsel_pkg::CNT_W'(lim);
		return op;
	endfunction

	function automatic list_op_t make_pace(input int unsigned sp, input int unsigned rp);
		list_op_t op;
		op = make_item(bsel_pkg::MODE_READ, '0, '0, '0);
		op.kind = OP_PACE;
		op.send_pct = sp;
		op.recv_pct = rp;
		return op;
	endfunction

	// Append one operation to the pending queue
	task automatic enqueue_op(input list_op_t op);
		pending_ops.insert(pending_ops.size(), op);
	endtask

	// Mostly small timestamps so that equal keys and reordering are common
	function automatic logic [bsel_pkg::TIME_W-1:0] pick_time(input int unsigned span);
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return '0;
			1: return '1;
			2: return $urandom();
			default: return bsel_pkg::TIME_W'($urandom_range(0, span));
		endcase
	endfunction

	// Insert-heavy mix keeps the list near full; the rest are random operations
	function automatic list_op_t random_item();
		int unsigned                 r;
		logic [bsel_pkg::MODE_W-1:0] m;
		logic [bsel_pkg::TIME_W-1:0] t;
		logic [bsel_pkg::CNT_W-1:0]  kc;
		r = $urandom_range(0, 99);
		t = $urandom();
		kc = bsel_pkg::CNT_W'($urandom_range(0, bsel_pkg::DEPTH));
		if (r < 12) begin
			m = bsel_pkg::MODE_READ;
		end else if (r < 20) begin
			m = bsel_pkg::MODE_PURGE;
			t = pick_time(12);
		end else if (r < 30) begin
			m = bsel_pkg::MODE_SHRINK;
			if ($urandom_range(0, 7) == 0)
				kc = bsel_pkg::CNT_W'($urandom_range(bsel_pkg::DEPTH + 1,
					(1 << bsel_pkg::CNT_W) - 1));
		end else if (r < 34) begin
			m = bsel_pkg::MODE_CLEAR;
		end else if (r < 38) begin
			m = bsel_pkg::MODE_W'(MODE_UNUSED_FIRST
				+ $urandom_range(0, MODE_UNUSED_LAST - MODE_UNUSED_FIRST));
		end else begin
			m = bsel_pkg::MODE_INSERT;
			t = pick_time(40);
		end
		return make_item(m, t,
			bsel_pkg::TAG_BITS'($urandom_range(0, (1 << bsel_pkg::TAG_BITS) - 1)), kc);
	endfunction

	function automatic list_result_t status_of(input int unsigned n);
		list_result_t r;
		r = '{count: bsel_pkg::CNT_W'(n), entry_valid: 1'b0, entry_time: '0, out_tag: '0,
			last: 1'b1};
		return r;
	endfunction

	// Apply one accepted item to the shadow list and queue the results it causes
	task automatic advance_list(input logic [bsel_pkg::MODE_W-1:0] m,
			input logic [bsel_pkg::TIME_W-1:0] t,
			input logic [bsel_pkg::TAG_BITS-1:0] tg, input logic [bsel_pkg::CNT_W-1:0] kc);
		int unsigned  cap;
		int unsigned  pos;
		int unsigned  i;
		list_result_t r;
		cap = (limit_now > bsel_pkg::DEPTH) ? bsel_pkg::DEPTH : limit_now;
		case (m)
			bsel_pkg::MODE_INSERT: begin
				// land after every entry with an equal or smaller key
				pos = 0;
				while (pos < shadow_held && shadow_time[pos] <= t)
					pos++;
				if (shadow_held < bsel_pkg::DEPTH) begin
					for (i = shadow_held; i > pos; i--) begin
						shadow_time[i] = shadow_time[i - 1];
						shadow_tag[i] = shadow_tag[i - 1];
					end
					shadow_time[pos] = t;
					shadow_tag[pos] = tg;
					shadow_held++;
					// over the limit: drop only the tail, even if still above it
					if (shadow_held > cap)
						shadow_held--;
				end else if (pos < bsel_pkg::DEPTH) begin
					// full: push the tail out, or drop the new entry if it lands past it
					for (i = bsel_pkg::DEPTH - 1; i > pos; i--) begin
						shadow_time[i] = shadow_time[i - 1];
						shadow_tag[i] = shadow_tag[i - 1];
					end
					shadow_time[pos] = t;
					shadow_tag[pos] = tg;
				end
			end
			bsel_pkg::MODE_PURGE: begin
				pos = 0;
				while (pos < shadow_held && shadow_time[pos] < t)
					pos++;
				for (i = pos; i < shadow_held; i++) begin
					shadow_time[i - pos] = shadow_time[i];
					shadow_tag[i - pos] = shadow_tag[i];
				end
				shadow_held -= pos;
			end
			bsel_pkg::MODE_SHRINK: begin
				if (shadow_held > kc)
					shadow_held = kc;
			end
			bsel_pkg::MODE_CLEAR: begin
				shadow_held = 0;
			end
			default: ;
		endcase
		if (m == bsel_pkg::MODE_READ && shadow_held > 0) begin
			for (i = 0; i < shadow_held; i++) begin
				r.count = bsel_pkg::CNT_W'(shadow_held);
				r.entry_valid = 1'b1;
				r.entry_time = shadow_time[i];
				r.out_tag = shadow_tag[i];
				r.last = (i + 1 == shadow_held);
				due_results.insert(due_results.size(), r);
			end
		end else begin
			due_results.insert(due_results.size(), status_of(shadow_held));
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	// Driver: present queued items, keep limit writes and pace changes at the falling edge
	always @(negedge clk) begin
		list_op_t head;
		logic     keep_up;
		logic     next_valid;
		keep_up = in_valid && !in_acc;
		next_valid = keep_up;
		if (cfg_valid && cfg_acc)
			cfg_valid = 1'b0;
		if (arst_n && !keep_up && !cfg_valid && pending_ops.size() > 0) begin
			head = pending_ops[0];
			case (head.kind)
				OP_ITEM: begin
					if ($urandom_range(0, 99) >= send_idle) begin
						pending_ops.delete(0);
						next_valid = 1'b1;
						mode = head.mode;
						time_value = head.stamp;
						entry_tag = head.tag;
						keep_count = head.keep;
					end
				end
				OP_LIMIT: begin
					// write only once every result is in and the block has gone quiet
					if (due_results.size() == 0 && calm >= CALM_CYCLES) begin
						pending_ops.delete(0);
						cfg_valid = 1'b1;
						keep_limit = head.new_limit;
					end
				end
				default: begin
					pending_ops.delete(0);
					send_idle = head.send_pct;
					recv_idle = head.recv_pct;
				end
			endcase
		end
		in_valid = next_valid;
	end

	// Receiver back-pressure
	always @(negedge clk)
		out_stall = ($urandom_range(0, 99) < recv_idle);

	// Monitor: track handshakes at the rising edge, predict and check results
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("status: fail");
				$finish;
			end else begin
				in_acc <= in_valid && !in_stall;
				cfg_acc <= cfg_valid && cfg_ready;
				if (cfg_valid && cfg_ready)
					limit_now = keep_limit;
				if (in_valid && !in_stall)
					advance_list(mode, time_value, entry_tag, keep_count);
				if (out_valid && !out_stall) begin
					if (due_results.size() == 0) begin
						errors++;
						$display("%0t: unexpected result, expected none, actual count %0d",
							$time, count);
					end else begin
						want = due_results.pop_front();
						check_field("count", 32'(want.count), 32'(count));
						check_field("entry_valid", 32'(want.entry_valid), 32'(entry_valid));
						check_field("entry_time", want.entry_time, entry_time);
						check_field("out_tag", 32'(want.out_tag), 32'(out_tag));
						check_field("last", 32'(want.last), 32'(last));
					end
				end
				calm <= (due_results.size() == 0 && !in_valid && !out_valid) ? calm + 1 : 0;
			end
		end
	end

	initial begin
		int ph;
		int blk;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		keep_limit = '0;
		in_valid = 1'b0;
		mode = bsel_pkg::MODE_INSERT;
		time_value = '0;
		entry_tag = '0;
		keep_count = '0;
		out_stall = 1'b0;

		// Directed: extremes, equal keys, every mode and the corner cases
		enqueue_op(make_pace(9, 79));
		enqueue_op(make_limit(bsel_pkg::DEPTH));
		enqueue_op(make_item(bsel_pkg::MODE_READ, '0, '0, '0));          // read while empty
		enqueue_op(make_item(bsel_pkg::MODE_INSERT, '0, '0, '0));
		enqueue_op(make_item(bsel_pkg::MODE_INSERT, '1, '1, '1));
		enqueue_op(make_item(bsel_pkg::MODE_INSERT, 32'd100, 16'h0001, '0));
		enqueue_op(make_item(bsel_pkg::MODE_INSERT, 32'd100, 16'h0002, '0)); // equal key after
		enqueue_op(make_item(bsel_pkg::MODE_INSERT, '0, 16'h0003, '0));
		enqueue_op(make_item(bsel_pkg::MODE_READ, '0, '0, '0));
		enqueue_op(make_item(bsel_pkg::MODE_PURGE, '0, '0, '0));         // bound 0 drops nothing
		enqueue_op(make_item(bsel_pkg::MODE_PURGE, 32'd100, '0, '0));
		enqueue_op(make_item(bsel_pkg::MODE_READ, '0, '0, '0));
		enqueue_op(make_item(bsel_pkg::MODE_SHRINK, '0, '0,
			bsel_pkg::CNT_W'(bsel_pkg::DEPTH)));                            // no change
		enqueue_op(make_item(bsel_pkg::MODE_SHRINK, '0, '0, '1));
		enqueue_op(make_item(bsel_pkg::MODE_SHRINK, '0, '0, bsel_pkg::CNT_W'(1)));
		enqueue_op(make_item(bsel_pkg::MODE_READ, '0, '0, '0));
		enqueue_op(make_item(MODE_UNUSED_FIRST, '1, '1, '1));
		enqueue_op(make_item(MODE_UNUSED_FIRST + 3'd1, '0, '0, '0));
		enqueue_op(make_item(MODE_UNUSED_LAST, '1, '1, '0));
		enqueue_op(make_item(bsel_pkg::MODE_CLEAR, '0, '0, '0));
		enqueue_op(make_item(bsel_pkg::MODE_READ, '0, '0, '0));
		enqueue_op(make_item(bsel_pkg::MODE_PURGE, '1, '0, '0));         // purge while empty
		enqueue_op(make_item(bsel_pkg::MODE_SHRINK, '0, '0, '0));
		enqueue_op(make_item(bsel_pkg::MODE_INSERT, '1, 16'h5A5A, '0));
		enqueue_op(make_item(bsel_pkg::MODE_PURGE, '1, '0, '0));         // equal key survives
		enqueue_op(make_item(bsel_pkg::MODE_READ, '0, '0, '0));
		enqueue_op(make_item(bsel_pkg::MODE_CLEAR, '0, '0, '0));

		// Random: three idling phases, each split by keep limit changes
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: enqueue_op(make_pace(9, 79));
				1: enqueue_op(make_pace(79, 9));
				default: enqueue_op(make_pace(0, 0));
			endcase
			for (blk = 0; blk < 3; blk++) begin
				enqueue_op(make_limit(limit_plan[ph * 3 + blk]));
				repeat (BLOCK_ITEMS)
					enqueue_op(random_item());
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every item is in and every result is out, then let the block settle
		while (!(pending_ops.size() == 0 && !in_valid && !cfg_valid && due_results.size() == 0))
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && due_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
